// ===== hdl/sbr_pkg.sv =====
`timescale 1ns / 1ps

package sbr_pkg;

   // Bit store capacity in bits.
   localparam int STORE_BITS = 64;
   // Width of the fill count, which must hold STORE_BITS itself.
   localparam int FILL_W = $clog2(STORE_BITS + 1);

   // Entries in the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Item kinds.
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // Byte values that the stuffing rule looks at.
   localparam logic [7:0] BYTE_FF = 8'hFF;
   localparam logic [7:0] BYTE_ZERO = 8'h00;

   // Largest read request.
   localparam logic [5:0] MAX_READ_BITS = 6'd32;

   // Result status codes.
   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_STUFFED = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd3;

   // Input item.
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       discard_stuffing;
      logic [5:0] read_bits;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [31:0] value;
      logic [5:0]  bits_read;
      logic [1:0]  status;
   } rsp_type;

   // Classified operation passed from the front to the back.
   typedef struct packed {
      logic       is_read;
      logic [7:0] data_byte;
      logic       stuff_zero;
      logic       is_ff;
      logic [5:0] read_bits;
   } op_type;

endpackage

// ===== hdl/stuffed_bit_reader_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  sbr_pkg::req_type (kind, byte, stuffing, bits)
// rsp       out        rsp_valid/rsp_stall  sbr_pkg::rsp_type (value, bits_read, status)
//
// One item is accepted per cycle while the queue has room, and each item yields exactly one result.
// When the queue is empty and no result is waiting, an accepted item is first
// written into the queue, and the back then does its shift and fill update from
// the queue head straight into the result register.
// Reset clears the bit store, fill count, stuffing flag, queue and output valid.
// A stalled result holds; the two-entry queue keeps accepting until it fills.

module stuffed_bit_reader_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sbr_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sbr_pkg::rsp_type rsp_item
);

   logic            queue_full;
   logic            queue_empty;
   logic            queue_push;
   logic            queue_pop;
   sbr_pkg::op_type push_op;
   sbr_pkg::op_type head_op;

   // Front: accept and classify items.
   sbr_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .push_op    (push_op)
   );

   // Queue between the front and the back.
   sbr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (queue_push),
      .push_op (push_op),
      .full    (queue_full),
      .pop     (queue_pop),
      .pop_op  (head_op),
      .empty   (queue_empty)
   );

   // Back: bit store and result register.
   sbr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_op     (head_op),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

endmodule

// ===== hdl/sbr_front.sv =====
`timescale 1ns / 1ps

module sbr_front (
   input  logic            req_valid,
   output logic            req_stall,
   input  sbr_pkg::req_type req_item,
   input  logic            queue_full,
   output logic            queue_push,
   output sbr_pkg::op_type push_op
);

   // The front takes an item whenever the queue has room.
   assign req_stall = queue_full;
   assign queue_push = req_valid && !queue_full;

   // Decode the item into the form the back executes.
   always_comb begin
      push_op.is_read = (req_item.kind == sbr_pkg::KIND_READ);
      push_op.data_byte = req_item.data_byte;
      push_op.stuff_zero = req_item.discard_stuffing &&
                           (req_item.data_byte == sbr_pkg::BYTE_ZERO);
      push_op.is_ff = (req_item.data_byte == sbr_pkg::BYTE_FF);
      // Requests above the limit are clamped to the limit.
      if (req_item.read_bits > sbr_pkg::MAX_READ_BITS) begin
         push_op.read_bits = sbr_pkg::MAX_READ_BITS;
      end else begin
         push_op.read_bits = req_item.read_bits;
      end
   end

endmodule

// ===== hdl/sbr_queue.sv =====
`timescale 1ns / 1ps

module sbr_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  sbr_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output sbr_pkg::op_type pop_op,
   output logic            empty
);

   sbr_pkg::op_type                 entry_ff [sbr_pkg::QUEUE_DEPTH];
   logic [sbr_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [sbr_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [sbr_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full = (count_ff == sbr_pkg::QCNT_W'(sbr_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign pop_op = entry_ff[rd_ptr_ff];

   // Pointer and count updates; push and pop may happen in the same cycle.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         if (wr_ptr_ff == sbr_pkg::QPTR_W'(sbr_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (pop) begin
         if (rd_ptr_ff == sbr_pkg::QPTR_W'(sbr_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== hdl/sbr_back.sv =====
`timescale 1ns / 1ps

module sbr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             queue_empty,
   input  sbr_pkg::op_type  head_op,
   output logic             queue_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sbr_pkg::rsp_type rsp_item
);

   logic [sbr_pkg::STORE_BITS-1:0] store_ff, store_in;
   logic [sbr_pkg::FILL_W-1:0]     fill_ff, fill_in;
   logic                           last_ff_byte_ff, last_ff_byte_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   sbr_pkg::rsp_type               rsp_ff, rsp_in;

   logic                           take;
   logic [sbr_pkg::FILL_W:0]       fill_plus_byte;
   logic                           store_full;
   logic [sbr_pkg::FILL_W-1:0]     want;
   logic                           underflow;
   logic [sbr_pkg::FILL_W-1:0]     shift_amt;
   logic [sbr_pkg::STORE_BITS-1:0] shifted;
   logic [31:0]                    read_mask;

   // Execute the head operation whenever the output register can take a result.
   assign take = !queue_empty && (!rsp_valid_ff || !rsp_stall);
   assign queue_pop = take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   // Capacity check for a push.
   assign fill_plus_byte = {1'b0, fill_ff} + (sbr_pkg::FILL_W + 1)'(8);
   assign store_full = (fill_plus_byte > (sbr_pkg::FILL_W + 1)'(sbr_pkg::STORE_BITS));

   // Bit extraction for a read: the oldest bits sit just below the fill count.
   assign want = sbr_pkg::FILL_W'(head_op.read_bits);
   assign underflow = (want > fill_ff);
   assign shift_amt = fill_ff - want;
   assign shifted = store_ff >> shift_amt;
   assign read_mask = ~(32'hFFFF_FFFF << head_op.read_bits);

   always_comb begin
      store_in = store_ff;
      fill_in = fill_ff;
      last_ff_byte_in = last_ff_byte_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_in.value = '0;
         rsp_in.bits_read = '0;
         rsp_in.status = sbr_pkg::STATUS_OK;
         if (!head_op.is_read) begin
            // Push: drop a stuffed zero, refuse a byte that does not fit.
            if (head_op.stuff_zero && last_ff_byte_ff) begin
               last_ff_byte_in = 1'b0;
               rsp_in.status = sbr_pkg::STATUS_STUFFED;
            end else if (store_full) begin
               rsp_in.status = sbr_pkg::STATUS_FULL;
            end else begin
               store_in = {store_ff[sbr_pkg::STORE_BITS-9:0], head_op.data_byte};
               fill_in = fill_ff + sbr_pkg::FILL_W'(8);
               last_ff_byte_in = head_op.is_ff;
            end
         end else begin
            // Read: underflow reports the fill and leaves the state alone.
            if (underflow) begin
               rsp_in.bits_read = 6'(fill_ff);
               rsp_in.status = sbr_pkg::STATUS_UNDERFLOW;
            end else begin
               rsp_in.value = shifted[31:0] & read_mask;
               rsp_in.bits_read = head_op.read_bits;
               fill_in = fill_ff - want;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         fill_ff <= '0;
         last_ff_byte_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         store_ff <= store_in;
         fill_ff <= fill_in;
         last_ff_byte_ff <= last_ff_byte_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule
